// ===== hw/rtl/hrl_pkg.sv =====
// ----------------------------------------------------------------------------
// hrl_pkg: shared types for the hex record loader
// Result kinds and the result payload carried from the parser to the output.
// ----------------------------------------------------------------------------
package hrl_pkg;

  typedef enum logic [2:0] {
    KIND_WRITE    = 3'd0,
    KIND_END_OK   = 3'd1,
    KIND_BAD_SUM  = 3'd2,
    KIND_NO_COLON = 3'd3,
    KIND_BAD_HEX  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  data;
  } result_t;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] REC_TYPE_EOF = 8'h01;

endpackage

// ===== hw/rtl/hrl_if.sv =====
// ----------------------------------------------------------------------------
// hrl_if: channel interfaces
// Character request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hrl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface hrl_rec_if;
  logic           valid;
  logic           ready;
  hrl_pkg::kind_t kind;
  logic [15:0]    address;
  logic [7:0]     data;

  modport source (output valid, output kind, output address, output data, input ready);
  modport sink   (input valid, input kind, input address, input data, output ready);
endinterface

// ===== hw/rtl/hrl_parse.sv =====
// ----------------------------------------------------------------------------
// hrl_parse: record parser
// Decodes one character per accepted request and updates the record state.
// ----------------------------------------------------------------------------
module hrl_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       character,
  output logic             res_vld,
  output hrl_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_COLON = 3'd0,
    PH_LEN   = 3'd1,
    PH_OFFS  = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CSUM  = 3'd5,
    PH_SKIP  = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  nib_cnt_r, nib_cnt_nxt;
  logic [15:0] asm_val_r, asm_val_nxt;
  logic [7:0]  rec_len_r, rec_len_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic [7:0]  rec_type_r, rec_type_nxt;
  logic [7:0]  byte_idx_r, byte_idx_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        halted_r, halted_nxt;

  logic [7:0]  c_fold;
  logic        is_hex;
  logic [3:0]  nib;
  logic [15:0] val;
  logic        last_nib;
  logic [7:0]  bi_inc;
  logic [7:0]  sum_csum;

  // fold lower case onto upper case above '9'
  always_comb begin
    c_fold = (character > 8'h39) ? (character & 8'hDF) : character;
    is_hex = 1'b0;
    nib    = 4'h0;
    if (c_fold >= 8'h30 && c_fold <= 8'h39) begin
      is_hex = 1'b1;
      nib    = c_fold[3:0];
    end else if (c_fold >= 8'h41 && c_fold <= 8'h46) begin
      is_hex = 1'b1;
      nib    = c_fold[3:0] + 4'd9;
    end
  end

  assign val      = {asm_val_r[11:0], nib};
  assign last_nib = (phase_r == PH_OFFS) ? (nib_cnt_r == 2'd3) : (nib_cnt_r != 2'd0);
  assign bi_inc   = byte_idx_r + 8'd1;
  assign sum_csum = sum_r + val[7:0];

  always_comb begin
    phase_nxt    = phase_r;
    nib_cnt_nxt  = nib_cnt_r;
    asm_val_nxt  = asm_val_r;
    rec_len_nxt  = rec_len_r;
    offset_nxt   = offset_r;
    rec_type_nxt = rec_type_r;
    byte_idx_nxt = byte_idx_r;
    sum_nxt      = sum_r;
    halted_nxt   = halted_r;
    res_vld      = 1'b0;
    res.kind     = hrl_pkg::KIND_WRITE;
    res.address  = 16'h0000;
    res.data     = 8'h00;

    if (acc && !halted_r) begin
      case (phase_r)
        PH_COLON: begin
          if (character == hrl_pkg::CHAR_COLON) begin
            sum_nxt      = 8'h00;
            nib_cnt_nxt  = 2'd0;
            asm_val_nxt  = 16'h0000;
            byte_idx_nxt = 8'h00;
            phase_nxt    = PH_LEN;
          end else begin
            halted_nxt = 1'b1;
            res_vld    = 1'b1;
            res.kind   = hrl_pkg::KIND_NO_COLON;
          end
        end
        PH_SKIP: begin
          if (character == hrl_pkg::CHAR_NEWLINE) begin
            phase_nxt = PH_COLON;
          end
        end
        PH_LEN, PH_OFFS, PH_TYPE, PH_DATA, PH_CSUM: begin
          if (!is_hex) begin
            halted_nxt = 1'b1;
            res_vld    = 1'b1;
            res.kind   = hrl_pkg::KIND_BAD_HEX;
          end else if (!last_nib) begin
            asm_val_nxt = val;
            nib_cnt_nxt = nib_cnt_r + 2'd1;
          end else begin
            nib_cnt_nxt = 2'd0;
            asm_val_nxt = 16'h0000;
            case (phase_r)
              PH_LEN: begin
                rec_len_nxt = val[7:0];
                sum_nxt     = sum_r + val[7:0];
                phase_nxt   = PH_OFFS;
              end
              PH_OFFS: begin
                offset_nxt = val;
                sum_nxt    = sum_r + val[15:8] + val[7:0];
                phase_nxt  = PH_TYPE;
              end
              PH_TYPE: begin
                rec_type_nxt = val[7:0];
                sum_nxt      = sum_r + val[7:0];
                byte_idx_nxt = 8'h00;
                phase_nxt    = (rec_len_r != 8'h00) ? PH_DATA : PH_CSUM;
              end
              PH_DATA: begin
                sum_nxt      = sum_r + val[7:0];
                byte_idx_nxt = bi_inc;
                if (bi_inc == rec_len_r) begin
                  phase_nxt = PH_CSUM;
                end
                if (rec_type_r != hrl_pkg::REC_TYPE_EOF) begin
                  res_vld     = 1'b1;
                  res.kind    = hrl_pkg::KIND_WRITE;
                  res.address = offset_r + {8'h00, byte_idx_r};
                  res.data    = val[7:0];
                end
              end
              default: begin
                sum_nxt = sum_csum;
                if (sum_csum != 8'h00) begin
                  halted_nxt = 1'b1;
                  res_vld    = 1'b1;
                  res.kind   = hrl_pkg::KIND_BAD_SUM;
                end else if (rec_type_r == hrl_pkg::REC_TYPE_EOF) begin
                  halted_nxt = 1'b1;
                  res_vld    = 1'b1;
                  res.kind   = hrl_pkg::KIND_END_OK;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end
            endcase
          end
        end
        default: begin
          // stray phase code: stop as on a bad digit
          halted_nxt = 1'b1;
          res_vld    = 1'b1;
          res.kind   = hrl_pkg::KIND_BAD_HEX;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_COLON;
      nib_cnt_r  <= 2'd0;
      asm_val_r  <= 16'h0000;
      rec_len_r  <= 8'h00;
      offset_r   <= 16'h0000;
      rec_type_r <= 8'h00;
      byte_idx_r <= 8'h00;
      sum_r      <= 8'h00;
      halted_r   <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      nib_cnt_r  <= nib_cnt_nxt;
      asm_val_r  <= asm_val_nxt;
      rec_len_r  <= rec_len_nxt;
      offset_r   <= offset_nxt;
      rec_type_r <= rec_type_nxt;
      byte_idx_r <= byte_idx_nxt;
      sum_r      <= sum_nxt;
      halted_r   <= halted_nxt;
    end
  end

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !res_vld)
    else $error("result produced while halted");

  a_halt_reported: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(halted_r) |-> $past(res_vld) && ($past(res.kind) != hrl_pkg::KIND_WRITE))
    else $error("halt without a terminal result");

  a_non_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.kind != hrl_pkg::KIND_WRITE) |-> (res.address == 16'h0000 &&
                                                      res.data == 8'h00))
    else $error("non-write result carries address or data");

  a_nib_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_OFFS) |-> (nib_cnt_r == 2'd0 || nib_cnt_r == 2'd1))
    else $error("nibble count out of range for byte field");

endmodule

// ===== hw/rtl/hrl_out_stage.sv =====
// ----------------------------------------------------------------------------
// hrl_out_stage: result register
// Holds one result until the sink takes it; frees in the same cycle it drains.
// ----------------------------------------------------------------------------
module hrl_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_vld,
  input  hrl_pkg::result_t up_res,
  output logic             up_ready,
  hrl_rec_if.source        out_ch
);

  logic             valid_r;
  hrl_pkg::result_t res_r;

  assign up_ready       = !valid_r || out_ch.ready;
  assign out_ch.valid   = valid_r;
  assign out_ch.kind    = res_r.kind;
  assign out_ch.address = res_r.address;
  assign out_ch.data    = res_r.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_vld) begin
      res_r <= up_res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    up_vld |-> up_ready)
    else $error("result offered while output register is full");

endmodule

// ===== hw/rtl/hex_record_loader.sv =====
// ----------------------------------------------------------------------------
// hex_record_loader: Intel HEX record parser
// Turns a hex text stream into program memory writes and a final status.
// ----------------------------------------------------------------------------
// One character is taken per clock unless the sink stalls. Each character is
// decoded in the cycle it is accepted and any result (a memory write, end of
// load, or an error) is presented from an output register on the next cycle.
// The input stays ready whenever that register is empty or being drained, so
// a full stream runs at one character per cycle; a stalled sink holds the
// input off once the output register is full. After an error or an end record
// the block keeps taking characters but gives no further result until reset.
module hex_record_loader (
  input  logic      clk,
  input  logic      rst_n,
  hrl_char_if.sink  in_ch,
  hrl_rec_if.source out_ch
);

  logic             acc;
  logic             stage_ready;
  logic             res_vld;
  hrl_pkg::result_t res;

  assign in_ch.ready = stage_ready;
  assign acc         = in_ch.valid && stage_ready;

  hrl_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .character (in_ch.character),
    .res_vld   (res_vld),
    .res       (res)
  );

  hrl_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (res_vld),
    .up_res   (res),
    .up_ready (stage_ready),
    .out_ch   (out_ch)
  );

endmodule
